// File: src/hlsla_pkg.sv
`timescale 1ns / 1ps

package hlsla_pkg;

    localparam int HLS_TOP  = 240;
    localparam int RGB_TOP  = 255;
    localparam int GRAY_HUE = 160;
    localparam int DIV_QW   = 8;

    localparam logic OP_DARKEN  = 1'b0;
    localparam logic OP_LIGHTEN = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] amount;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } out_t;

    // floor(x / 240) for x < 2^17: floor(floor(x / 16) / 15) by reciprocal
    function automatic logic [8:0] div240(input logic [16:0] x);
        logic [12:0] y;
        logic [26:0] p;
        y = x[16:4];
        p = 27'(y) * 27'(14'd8739);
        return p[25:17];
    endfunction

    // floor(x / 40) for x < 2^14: floor(floor(x / 8) / 5) by reciprocal
    function automatic logic [7:0] div40(input logic [13:0] x);
        logic [10:0] y;
        logic [21:0] p;
        y = x[13:3];
        p = 22'(y) * 22'(11'd1639);
        return p[20:13];
    endfunction

    // floor(x / 510) for quotients below 256: floor(floor(x / 2) / 255),
    // with y / 255 = (y + (y >> 8) + 1) >> 8 for y < 2^16
    function automatic logic [7:0] div510(input logic [16:0] x);
        logic [16:0] t;
        t = 17'(x[16:1]) + 17'(x[16:9]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: src/hlsla_div.sv
`timescale 1ns / 1ps

module hlsla_div #(
    parameter int DW = 16,
    parameter int VW = 9,
    parameter int QW = hlsla_pkg::DIV_QW
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    localparam int W = (DW > VW + QW) ? DW : VW + QW;

    logic [W-1:0]  rem_reg [QW];
    logic [VW-1:0] dv_reg  [QW];
    logic [QW-1:0] q_reg   [QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= W'(dividend);
            dv_reg[0]  <= divisor;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  shd;
        logic          ge;
        logic [QW-1:0] qin;

        assign shd = W'(dv_reg[k]) << (QW - 1 - k);
        assign ge  = rem_reg[k] >= shd;

        if (k == 0) begin : g_first
            assign qin = '0;
        end else begin : g_rest
            assign qin = q_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k] <= {qin[QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_fwd
            logic [W-1:0] rem_next;
            assign rem_next = ge ? rem_reg[k] - shd : rem_reg[k];
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    dv_reg[k+1]  <= dv_reg[k];
                end
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

// File: src/hls_lightness_adjust.sv
`timescale 1ns / 1ps

// Lightness adjust on one RGBA pixel per clock unless the output stalls: RGB to HLS on a
// 0..240 scale, lightness lowered (darken) or raised (lighten) by amount with clamping, then
// back to RGB; alpha passes through. Fully pipelined: a transaction may be accepted every
// cycle while s_ready is high. The pipeline is the input register, the 9-stage pipelined
// dividers (operand register plus one quotient bit per stage, for saturation and the three
// hue terms; lightness comes from a reciprocal in the input stage and rides alongside)
// and six stages of hue, lightness and channel arithmetic. s_ready drops only while the
// output register holds a result that is not taken.

module hls_lightness_adjust (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hlsla_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hlsla_pkg::out_t   m_data
);

    localparam int QW      = hlsla_pkg::DIV_QW;
    localparam int DIV_LAT = QW + 1;
    localparam int NST     = DIV_LAT + 7;

    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] amount;
        logic [7:0] alpha;
        logic [7:0] lum;
        logic       r_is_hi;
        logic       g_is_hi;
        logic       gray;
    } side_t;

    logic             adv;
    logic [NST-1:0]   v_reg;

    assign adv     = !v_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_valid};
        end
    end

    // stage 0: input register
    hlsla_pkg::in_t in_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg <= s_data;
        end
    end

    logic [7:0]  hi, lo, dif;
    logic [8:0]  sum, sat_dv;
    logic [16:0] lum_dvd;
    logic [15:0] sat_dvd;
    logic [13:0] rd_dvd, gd_dvd, bd_dvd;
    side_t       side_next;

    always_comb begin
        hi = (in_reg.red_in > in_reg.green_in) ? in_reg.red_in : in_reg.green_in;
        lo = (in_reg.red_in < in_reg.green_in) ? in_reg.red_in : in_reg.green_in;
        if (in_reg.blue_in > hi) begin
            hi = in_reg.blue_in;
        end
        if (in_reg.blue_in < lo) begin
            lo = in_reg.blue_in;
        end
        dif     = hi - lo;
        sum     = {1'b0, hi} + {1'b0, lo};
        lum_dvd = 17'(sum) * 17'd240 + 17'd255;
        // lightness <= 120 exactly when hi + lo <= 256
        sat_dv  = (sum <= 9'd256) ? sum : 9'd510 - sum;
        sat_dvd = 16'(dif) * 16'd240 + 16'(sat_dv >> 1);
        rd_dvd  = 14'(hi - in_reg.red_in) * 14'd40 + 14'(dif >> 1);
        gd_dvd  = 14'(hi - in_reg.green_in) * 14'd40 + 14'(dif >> 1);
        bd_dvd  = 14'(hi - in_reg.blue_in) * 14'd40 + 14'(dif >> 1);
        side_next.operation = in_reg.operation;
        side_next.amount    = in_reg.amount;
        side_next.alpha     = in_reg.alpha_in;
        side_next.lum       = hlsla_pkg::div510(lum_dvd);
        side_next.r_is_hi   = in_reg.red_in == hi;
        side_next.g_is_hi   = in_reg.green_in == hi;
        side_next.gray      = hi == lo;
    end

    logic [QW-1:0] sat_q, rd_q, gd_q, bd_q;

    hlsla_div #(.DW(16), .VW(9), .QW(QW)) u_div_sat (
        .aclk(aclk), .en(adv), .dividend(sat_dvd), .divisor(sat_dv), .quotient(sat_q)
    );
    hlsla_div #(.DW(14), .VW(8), .QW(QW)) u_div_rd (
        .aclk(aclk), .en(adv), .dividend(rd_dvd), .divisor(dif), .quotient(rd_q)
    );
    hlsla_div #(.DW(14), .VW(8), .QW(QW)) u_div_gd (
        .aclk(aclk), .en(adv), .dividend(gd_dvd), .divisor(dif), .quotient(gd_q)
    );
    hlsla_div #(.DW(14), .VW(8), .QW(QW)) u_div_bd (
        .aclk(aclk), .en(adv), .dividend(bd_dvd), .divisor(dif), .quotient(bd_q)
    );

    side_t side_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage E: hue and adjusted lightness
    side_t            sd;
    logic signed [9:0] hue_raw;
    logic [8:0]        lum_sum;
    logic [7:0]        hue_next, lum_next, sat_next;
    logic [7:0]        e_hue_reg, e_lum_reg, e_sat_reg, e_alpha_reg;

    always_comb begin
        sd = side_reg[DIV_LAT-1];
        if (sd.r_is_hi) begin
            hue_raw = $signed(10'(bd_q)) - $signed(10'(gd_q));
        end else if (sd.g_is_hi) begin
            hue_raw = 10'sd80 + $signed(10'(rd_q)) - $signed(10'(bd_q));
        end else begin
            hue_raw = 10'sd160 + $signed(10'(gd_q)) - $signed(10'(rd_q));
        end
        if (hue_raw < 0) begin
            hue_raw = hue_raw + 10'sd240;
        end
        if (hue_raw > 10'sd240) begin
            hue_raw = hue_raw - 10'sd240;
        end
        hue_next = hue_raw[7:0];
        lum_sum  = 9'(sd.lum) + 9'(sd.amount);
        if (sd.operation == hlsla_pkg::OP_LIGHTEN) begin
            lum_next = (lum_sum > 9'd240) ? 8'd240 : lum_sum[7:0];
        end else begin
            lum_next = (sd.lum < sd.amount) ? 8'd0 : sd.lum - sd.amount;
        end
        sat_next = sd.gray ? 8'd0 : sat_q;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_hue_reg   <= hue_next;
            e_lum_reg   <= lum_next;
            e_sat_reg   <= sat_next;
            e_alpha_reg <= sd.alpha;
        end
    end

    // stage F: products for m2 and for the gray level
    logic [16:0] f_prod_reg;
    logic [15:0] f_gray_reg;
    logic        f_low_reg;
    logic [7:0]  f_lum_reg, f_sat_reg, f_hue_reg, f_alpha_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_low_reg   <= e_lum_reg <= 8'd120;
            f_prod_reg  <= (e_lum_reg <= 8'd120)
                         ? 17'(e_lum_reg) * (17'd240 + 17'(e_sat_reg))
                         : 17'(e_lum_reg) * 17'(e_sat_reg);
            f_gray_reg  <= (16'(e_lum_reg) << 8) - 16'(e_lum_reg);
            f_lum_reg   <= e_lum_reg;
            f_sat_reg   <= e_sat_reg;
            f_hue_reg   <= e_hue_reg;
            f_alpha_reg <= e_alpha_reg;
        end
    end

    // stage G: m1, m2 and the three hue offsets
    logic [8:0] q_m2, m2_next, m1_next, gray_q, hr_sum;
    logic [7:0] hr_next, hb_next;
    logic [7:0] g_m1_reg, g_m2_reg, g_gray_reg, g_alpha_reg;
    logic [7:0] g_h_reg [3];
    logic       g_flat_reg;

    always_comb begin
        q_m2    = hlsla_pkg::div240(f_prod_reg + 17'd120);
        m2_next = f_low_reg ? q_m2 : 9'(f_lum_reg) + 9'(f_sat_reg) - q_m2;
        m1_next = (9'(f_lum_reg) << 1) - m2_next;
        gray_q  = hlsla_pkg::div240(17'(f_gray_reg));
        hr_sum  = 9'(f_hue_reg) + 9'd80;
        hr_next = (hr_sum > 9'd240) ? 8'(hr_sum - 9'd240) : hr_sum[7:0];
        hb_next = (f_hue_reg < 8'd80) ? f_hue_reg + 8'd160 : f_hue_reg - 8'd80;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_m1_reg    <= m1_next[7:0];
            g_m2_reg    <= m2_next[7:0];
            g_gray_reg  <= gray_q[7:0];
            g_flat_reg  <= f_sat_reg == 8'd0;
            g_h_reg[0]  <= hr_next;
            g_h_reg[1]  <= f_hue_reg;
            g_h_reg[2]  <= hb_next;
            g_alpha_reg <= f_alpha_reg;
        end
    end

    // stage H: segment of the hue ramp and interpolation product
    logic [13:0] h_prod_reg [3];
    logic [1:0]  h_seg_reg  [3];
    logic [7:0]  h_m1_reg, h_m2_reg, h_gray_reg, h_alpha_reg;
    logic        h_flat_reg;
    logic [1:0]  seg_next  [3];
    logic [7:0]  t_next    [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (g_h_reg[c] < 8'd40) begin
                seg_next[c] = SEG_RISE;
                t_next[c]   = g_h_reg[c];
            end else if (g_h_reg[c] < 8'd120) begin
                seg_next[c] = SEG_HIGH;
                t_next[c]   = 8'd0;
            end else if (g_h_reg[c] < 8'd160) begin
                seg_next[c] = SEG_FALL;
                t_next[c]   = 8'd160 - g_h_reg[c];
            end else begin
                seg_next[c] = SEG_LOW;
                t_next[c]   = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                h_seg_reg[c]  <= seg_next[c];
                h_prod_reg[c] <= 14'(g_m2_reg - g_m1_reg) * 14'(t_next[c]);
            end
            h_m1_reg    <= g_m1_reg;
            h_m2_reg    <= g_m2_reg;
            h_gray_reg  <= g_gray_reg;
            h_flat_reg  <= g_flat_reg;
            h_alpha_reg <= g_alpha_reg;
        end
    end

    // stage I: channel level on the 0..240 scale
    logic [7:0] i_c_reg [3];
    logic [7:0] i_gray_reg, i_alpha_reg;
    logic       i_flat_reg;
    logic [7:0] c_next  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (h_seg_reg[c])
                SEG_RISE, SEG_FALL: begin
                    c_next[c] = h_m1_reg + hlsla_pkg::div40(h_prod_reg[c] + 14'd20);
                end
                SEG_HIGH: c_next[c] = h_m2_reg;
                default:  c_next[c] = h_m1_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                i_c_reg[c] <= c_next[c];
            end
            i_gray_reg  <= h_gray_reg;
            i_flat_reg  <= h_flat_reg;
            i_alpha_reg <= h_alpha_reg;
        end
    end

    // stage J: rescale to 0..255, output register
    logic [8:0]      o_q  [3];
    logic [7:0]      o_c  [3];
    hlsla_pkg::out_t out_next;
    hlsla_pkg::out_t out_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_q[c] = hlsla_pkg::div240((17'(i_c_reg[c]) << 8) - 17'(i_c_reg[c]) + 17'd120);
            if (i_flat_reg) begin
                o_c[c] = i_gray_reg;
            end else begin
                o_c[c] = (o_q[c] > 9'd255) ? 8'd255 : o_q[c][7:0];
            end
        end
        out_next.red_out   = o_c[0];
        out_next.green_out = o_c[1];
        out_next.blue_out  = o_c[2];
        out_next.alpha_out = i_alpha_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// File: src/hlsla_checker.sv
`timescale 1ns / 1ps

module hlsla_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input hlsla_pkg::out_t m_data
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_ready_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while result taken");

endmodule

bind hls_lightness_adjust hlsla_checker u_hlsla_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/tb_hls_lightness_adjust.sv
`timescale 1ns / 1ps

module tb_hls_lightness_adjust;

    localparam int LATENCY = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam int HLS_TOP  = hlsla_pkg::HLS_TOP;
    localparam int RGB_TOP  = hlsla_pkg::RGB_TOP;
    localparam int GRAY_HUE = hlsla_pkg::GRAY_HUE;

    localparam logic OP_DARKEN  = hlsla_pkg::OP_DARKEN;
    localparam logic OP_LIGHTEN = hlsla_pkg::OP_LIGHTEN;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    hlsla_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    hlsla_pkg::out_t m_data;

    hlsla_pkg::out_t pixel_q[$];
    int   mismatches;
    int   pixels_sent;
    int   pixels_checked;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    hls_lightness_adjust dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int hue_to_chan(int lo, int hi, int h);
        if (h < 0) h += HLS_TOP;
        if (h > HLS_TOP) h -= HLS_TOP;
        if (h < HLS_TOP / 6) return lo + ((hi - lo) * h + HLS_TOP / 12) / (HLS_TOP / 6);
        if (h < HLS_TOP / 2) return hi;
        if (h < HLS_TOP * 2 / 3)
            return lo + ((hi - lo) * (HLS_TOP * 2 / 3 - h) + HLS_TOP / 12) / (HLS_TOP / 6);
        return lo;
    endfunction

    function automatic logic [7:0] clip8(int v);
        if (v < 0) return 8'd0;
        if (v > RGB_TOP) return 8'd255;
        return v[7:0];
    endfunction

    function automatic hlsla_pkg::out_t adjust_pixel(hlsla_pkg::in_t p);
        int r, g, b, hi, lo, lum, sat, hue, d, s, rd, gd, bd, m1, m2, ro, go, bo;
        hlsla_pkg::out_t o;
        r = p.red_in;
        g = p.green_in;
        b = p.blue_in;
        hi = (r > g) ? r : g;
        lo = (r < g) ? r : g;
        if (b > hi) hi = b;
        if (b < lo) lo = b;
        lum = ((hi + lo) * HLS_TOP + RGB_TOP) / (2 * RGB_TOP);
        sat = 0;
        hue = GRAY_HUE;
        if (hi != lo) begin
            d = hi - lo;
            s = hi + lo;
            if (lum <= HLS_TOP / 2) sat = (d * HLS_TOP + s / 2) / s;
            else sat = (d * HLS_TOP + (2 * RGB_TOP - s) / 2) / (2 * RGB_TOP - s);
            rd = ((hi - r) * (HLS_TOP / 6) + d / 2) / d;
            gd = ((hi - g) * (HLS_TOP / 6) + d / 2) / d;
            bd = ((hi - b) * (HLS_TOP / 6) + d / 2) / d;
            if (r == hi) hue = bd - gd;
            else if (g == hi) hue = HLS_TOP / 3 + rd - bd;
            else hue = 2 * HLS_TOP / 3 + gd - rd;
            if (hue < 0) hue += HLS_TOP;
            if (hue > HLS_TOP) hue -= HLS_TOP;
        end
        if (p.operation == OP_LIGHTEN) begin
            lum += p.amount;
            if (lum > HLS_TOP) lum = HLS_TOP;
        end else begin
            lum -= p.amount;
            if (lum < 0) lum = 0;
        end
        if (sat == 0) begin
            ro = lum * RGB_TOP / HLS_TOP;
            go = ro;
            bo = ro;
        end else begin
            if (lum <= HLS_TOP / 2) m2 = (lum * (HLS_TOP + sat) + HLS_TOP / 2) / HLS_TOP;
            else m2 = lum + sat - (lum * sat + HLS_TOP / 2) / HLS_TOP;
            m1 = 2 * lum - m2;
            ro = (hue_to_chan(m1, m2, hue + HLS_TOP / 3) * RGB_TOP + HLS_TOP / 2) / HLS_TOP;
            go = (hue_to_chan(m1, m2, hue) * RGB_TOP + HLS_TOP / 2) / HLS_TOP;
            bo = (hue_to_chan(m1, m2, hue - HLS_TOP / 3) * RGB_TOP + HLS_TOP / 2) / HLS_TOP;
        end
        o.red_out   = clip8(ro);
        o.green_out = clip8(go);
        o.blue_out  = clip8(bo);
        o.alpha_out = p.alpha_in;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want,
                 pixels_checked);
        mismatches++;
    endtask

    // called and returns at a falling edge; s_valid stays high between back-to-back sends
    task automatic send_pixel(logic op, logic [7:0] amt, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic [7:0] a);
        hlsla_pkg::in_t p;
        p.operation = op;
        p.amount    = amt;
        p.red_in    = r;
        p.green_in  = g;
        p.blue_in   = b;
        p.alpha_in  = a;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixel_q.push_back(adjust_pixel(p));
        pixels_sent++;
        @(negedge aclk);
    endtask

    // receiver stalls at random; results checked on the rising edge
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $display("mismatch: unexpected result transaction");
                mismatches++;
            end else begin
                hlsla_pkg::out_t e;
                e = pixel_q.pop_front();
                if (m_data.red_out !== e.red_out)
                    report_mismatch("red_out", m_data.red_out, e.red_out);
                if (m_data.green_out !== e.green_out)
                    report_mismatch("green_out", m_data.green_out, e.green_out);
                if (m_data.blue_out !== e.blue_out)
                    report_mismatch("blue_out", m_data.blue_out, e.blue_out);
                if (m_data.alpha_out !== e.alpha_out)
                    report_mismatch("alpha_out", m_data.alpha_out, e.alpha_out);
            end
            pixels_checked++;
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("hls_lightness_adjust test failed");
            $finish;
        end
    end

    task automatic test_extremes();
        send_pixel(OP_DARKEN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_LIGHTEN, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(OP_LIGHTEN, 8'd240, 8'd0, 8'd0, 8'd0, 8'hAA);
        send_pixel(OP_DARKEN, 8'd240, 8'd255, 8'd255, 8'd255, 8'h55);
        send_pixel(OP_LIGHTEN, 8'd255, 8'd10, 8'd200, 8'd30, 8'd1);
        send_pixel(OP_DARKEN, 8'd255, 8'd10, 8'd200, 8'd30, 8'd254);
        send_pixel(OP_LIGHTEN, 8'd128, 8'd128, 8'd127, 8'd1, 8'd128);
    endtask

    task automatic test_gray_and_hues();
        send_pixel(OP_LIGHTEN, 8'd20, 8'd100, 8'd100, 8'd100, 8'd7);
        send_pixel(OP_DARKEN, 8'd20, 8'd100, 8'd100, 8'd100, 8'd7);
        send_pixel(OP_DARKEN, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_DARKEN, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
        send_pixel(OP_DARKEN, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
        send_pixel(OP_LIGHTEN, 8'd30, 8'd255, 8'd0, 8'd10, 8'd9);
        send_pixel(OP_LIGHTEN, 8'd30, 8'd255, 8'd10, 8'd0, 8'd9);
        send_pixel(OP_DARKEN, 8'd50, 8'd255, 8'd255, 8'd0, 8'd9);
        send_pixel(OP_DARKEN, 8'd50, 8'd0, 8'd255, 8'd255, 8'd9);
        send_pixel(OP_LIGHTEN, 8'd10, 8'd255, 8'd0, 8'd255, 8'd9);
        send_pixel(OP_LIGHTEN, 8'd5, 8'd200, 8'd250, 8'd240, 8'd9);
        send_pixel(OP_DARKEN, 8'd5, 8'd1, 8'd0, 8'd0, 8'd9);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            logic [7:0] amt;
            logic [7:0] gr;
            amt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(60));
            if ($urandom_range(15) == 0) begin
                gr = 8'($urandom);
                send_pixel(1'($urandom), amt, gr, gr, gr, 8'($urandom));
            end else
                send_pixel(1'($urandom), amt, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
        end
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        int waited;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        mismatches     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        cycles         = 0;
        set_idling(0, 0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_extremes();
        test_gray_and_hues();
        test_random(100);
        set_idling(66, 0);
        test_random(100);
        set_idling(0, 66);
        test_random(100);
        set_idling(25, 25);
        test_random(100);
        s_valid <= 1'b0;
        set_idling(0, 0);

        waited = 0;
        while (pixel_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY * 2) @(posedge aclk);

        $display("%0d pixels sent, %0d results checked: directed extremes, grey and hue",
                 pixels_sent, pixels_checked);
        $display("cases, then random pixels under four idling patterns");
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("hls_lightness_adjust test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pixel_q.size());
            $display("hls_lightness_adjust test failed");
        end
        $finish;
    end

endmodule
